[src/lzwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants for the hashed LZW compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int TAG_W    = 8;
    localparam int CFG_W    = 5;
    localparam int MIN_BITS = 12;

    // Code selector for the packer
    localparam logic [1:0] SEL_PREFIX = 2'd0;
    localparam logic [1:0] SEL_END    = 2'd1;
    localparam logic [1:0] SEL_ZERO   = 2'd2;

    typedef struct packed {
        logic       load_in;    // capture input word
        logic       msg_start;  // first byte of a message
        logic       hash;       // compute first probe index
        logic       step;       // advance to next probe index
        logic       hit;        // take matched code as prefix
        logic       miss;       // insert entry, emit prefix
        logic       pk_load;    // push selected code into packer
        logic [1:0] code_sel;
        logic       drain;      // move one packed byte out
        logic       final_code; // last code of the message
        logic       clr;        // clear sweep active
    } lzwc_cmd_t;

    typedef struct packed {
        logic hit;
        logic empty;
        logic ge8;
        logic clr_done;
        logic epoch_max;
        logic last;
    } lzwc_stat_t;

    // Prime table size per code width
    function automatic logic [16:0] size_for(input logic [CFG_W-1:0] w);
        logic [16:0] s;
        begin
            case (w)
                5'd13:   s = 17'd9029;
                5'd14:   s = 17'd18041;
                5'd15:   s = 17'd36251;
                5'd16:   s = 17'd74521;
                default: s = 17'd5021;
            endcase
            return s;
        end
    endfunction

endpackage

[src/lzw_hashed_compressor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_hashed_compressor
// LZW compressor with 12..16 bit codes and an open-probed hashed string table.
// ----------------------------------------------------------------------------
// A byte that hits in the table goes through accept, read, compare and check;
// each extra probe repeats read and compare (one table read port, registered).
// A miss goes from compare to the drain loop, which moves out each packed word
// and then leaves for check; the word then sits in the output register. The first
// byte of a message goes through accept and check only. A new byte is taken only
// once the previous one is done, and output stalls hold the drain loop; message
// end emits the last prefix, the end code and two zero codes, each drained out.
// Reset (synchronous, aresetn low) clears control state
// and starts a tag sweep over all TABLE_DEPTH entries; no word is taken meanwhile.
// The same sweep recurs once every 255 messages when the entry tag wraps.
// ----------------------------------------------------------------------------
module lzw_hashed_compressor import lzwc_pkg::*; #(
    parameter int TABLE_DEPTH   = 74521,
    parameter int MAX_CODE_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    // code width register
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,   // code_bits
    // raw message bytes
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,       // data_byte
    input  logic             s_tlast,       // last_byte
    // packed code stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,       // out_byte
    output logic             m_tlast        // out_last
);

    lzwc_cmd_t  cmd;
    lzwc_stat_t stat;

    // Controller: sweep, probe loop, emit/flush sequencing
    lzwc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: table with epoch tags, hash/probe, MSB-first packer
    lzwc_datapath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

[src/lzwc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_ctrl
// Sequencer: table sweep, probe loop, code emission and flush.
// ----------------------------------------------------------------------------
module lzwc_ctrl import lzwc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  lzwc_stat_t stat,
    output lzwc_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_CHK   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       in_msg_reg, in_msg_next;
    logic       final_reg, final_next;
    logic [1:0] phase_reg, phase_next;
    logic       resume_reg, resume_next;
    logic       acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tready & s_tvalid;

    always_comb begin
        state_next  = state_reg;
        in_msg_next = in_msg_reg;
        final_next  = final_reg;
        phase_next  = phase_reg;
        resume_next = resume_reg;
        cmd         = '0;
        cmd.code_sel = (phase_reg == 2'd0) ? SEL_PREFIX :
                       (phase_reg == 2'd1) ? SEL_END : SEL_ZERO;
        cmd.final_code = final_reg & (phase_reg == 2'd3);
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.clr_done) begin
                    state_next  = resume_reg ? ST_CHK : ST_IDLE;
                    resume_next = 1'b0;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    cmd.load_in = 1'b1;
                    if (!in_msg_reg) begin
                        cmd.msg_start = 1'b1;
                        in_msg_next   = 1'b1;
                        if (stat.epoch_max) begin
                            state_next  = ST_CLEAR;
                            resume_next = 1'b1;
                        end else begin
                            state_next = ST_CHK;
                        end
                    end else begin
                        cmd.hash   = 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: state_next = ST_CMP;
            ST_CMP: begin
                if (stat.hit) begin
                    cmd.hit    = 1'b1;
                    state_next = ST_CHK;
                end else if (stat.empty) begin
                    cmd.miss   = 1'b1;
                    state_next = ST_DRAIN;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_CHK: begin
                if (stat.last) begin
                    final_next = 1'b1;
                    phase_next = 2'd0;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                cmd.pk_load = 1'b1;
                state_next  = ST_DRAIN;
            end
            ST_DRAIN: begin
                cmd.drain = 1'b1;
                if (!stat.ge8) begin
                    if (!final_reg) begin
                        state_next = ST_CHK;
                    end else if (phase_reg == 2'd3) begin
                        final_next  = 1'b0;
                        in_msg_next = 1'b0;
                        state_next  = ST_IDLE;
                    end else begin
                        phase_next = phase_reg + 2'd1;
                        state_next = ST_EMIT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            in_msg_reg <= 1'b0;
            final_reg  <= 1'b0;
            phase_reg  <= 2'd0;
            resume_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            in_msg_reg <= in_msg_next;
            final_reg  <= final_next;
            phase_reg  <= phase_next;
            resume_reg <= resume_next;
        end
    end

endmodule

[src/lzwc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_datapath
// String table memory, hash probe, code packer and output register.
// ----------------------------------------------------------------------------
module lzwc_datapath import lzwc_pkg::*; #(
    parameter int TABLE_DEPTH   = 74521,
    parameter int MAX_CODE_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    input  lzwc_cmd_t        cmd,
    output lzwc_stat_t       stat
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = MAX_CODE_BITS;
    localparam int HW  = (AW > CW) ? AW : CW;
    localparam int MAX_W = (MAX_CODE_BITS > 16) ? 16 : MAX_CODE_BITS;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CW-1:0]    code;
        logic [CW-1:0]    prefix;
        logic [7:0]       append;
    } entry_t;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    logic [CFG_W-1:0] code_bits_reg;
    logic [CFG_W-1:0] width_reg;
    logic [AW-1:0]    size_reg;
    logic [TAG_W-1:0] epoch_reg;
    logic [CW:0]      next_free_reg;
    logic [CW-1:0]    prefix_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [AW-1:0]    idx_reg, off_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic [31:0]      pack_buf_reg;
    logic [4:0]       pack_cnt_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    // width check for a new message
    logic [CFG_W-1:0] w_ok;
    always_comb begin
        if (code_bits_reg < CFG_W'(MIN_BITS) || code_bits_reg > CFG_W'(MAX_W) ||
            size_for(code_bits_reg) > 17'(TABLE_DEPTH))
            w_ok = CFG_W'(MIN_BITS);
        else
            w_ok = code_bits_reg;
    end

    // hash: value always below the table size, so no reduction needed
    logic [HW-1:0] hval;
    logic [AW-1:0] h_idx, h_off;
    assign hval  = (HW'(s_tdata) << (width_reg - CFG_W'(8))) ^ HW'(prefix_reg);
    assign h_idx = AW'(hval);
    assign h_off = (h_idx == '0) ? AW'(1) : size_reg - h_idx;

    logic [AW:0]   wrap_sum;
    logic [AW-1:0] step_idx;
    assign wrap_sum = {1'b0, idx_reg} + {1'b0, size_reg} - {1'b0, off_reg};
    assign step_idx = (idx_reg >= off_reg) ? idx_reg - off_reg : wrap_sum[AW-1:0];

    logic entry_valid, can_add;
    logic [CW:0] code_limit;
    assign entry_valid = (rd_data_reg.tag == epoch_reg);
    assign code_limit  = ((CW+1)'(1) << width_reg) - (CW+1)'(2);
    assign can_add     = (next_free_reg <= code_limit);

    assign stat.hit = entry_valid && rd_data_reg.prefix == prefix_reg &&
                      rd_data_reg.append == byte_reg;
    assign stat.empty     = !entry_valid;
    assign stat.ge8       = (pack_cnt_reg >= 5'd8);
    assign stat.clr_done  = (clr_addr_reg == AW'(TABLE_DEPTH - 1));
    assign stat.epoch_max = (epoch_reg == '1);
    assign stat.last      = last_reg;

    // code entering the packer
    logic [31:0] code_in;
    logic [CW-1:0] sel_code, code_mask;
    logic [5:0]  sh;
    assign code_mask = CW'(({{CW{1'b0}}, 1'b1} << width_reg) - 1'b1);
    always_comb begin
        case (cmd.code_sel)
            SEL_PREFIX: sel_code = prefix_reg;
            SEL_END:    sel_code = code_mask;
            default:    sel_code = '0;
        endcase
    end
    assign sh      = 6'd32 - 6'(width_reg) - 6'(pack_cnt_reg);
    assign code_in = (32'(cmd.miss ? prefix_reg : sel_code) & 32'(code_mask)) << sh;

    logic out_free, drain_fire;
    assign out_free   = !out_valid_reg || m_tready;
    assign drain_fire = cmd.drain && stat.ge8 && out_free;

    // table memory
    logic   wr_en;
    logic [AW-1:0] wr_addr;
    entry_t wr_data;
    assign wr_en   = cmd.clr || (cmd.miss && can_add);
    assign wr_addr = cmd.clr ? clr_addr_reg : idx_reg;
    always_comb begin
        wr_data = '0;
        if (!cmd.clr) begin
            wr_data.tag    = epoch_reg;
            wr_data.code   = next_free_reg[CW-1:0];
            wr_data.prefix = prefix_reg;
            wr_data.append = byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (cmd.hash) begin
            idx_reg <= h_idx;
            off_reg <= h_off;
        end else if (cmd.step) begin
            idx_reg <= step_idx;
        end
        if (cmd.msg_start)
            prefix_reg <= CW'(s_tdata);
        else if (cmd.hit)
            prefix_reg <= rd_data_reg.code;
        else if (cmd.miss)
            prefix_reg <= CW'(byte_reg);
        if (drain_fire) begin
            out_byte_reg <= pack_buf_reg[31:24];
            out_last_reg <= cmd.final_code && (pack_cnt_reg < 5'd16);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_bits_reg <= CFG_W'(MIN_BITS);
            width_reg     <= CFG_W'(MIN_BITS);
            size_reg      <= AW'(size_for(CFG_W'(MIN_BITS)));
            epoch_reg     <= '0;
            next_free_reg <= (CW+1)'(256);
            clr_addr_reg  <= '0;
            pack_buf_reg  <= '0;
            pack_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en)
                code_bits_reg <= cfg_wr_data;
            if (cmd.msg_start) begin
                width_reg     <= w_ok;
                size_reg      <= AW'(size_for(w_ok));
                epoch_reg     <= stat.epoch_max ? TAG_W'(1) : epoch_reg + TAG_W'(1);
                next_free_reg <= (CW+1)'(256);
                pack_buf_reg  <= '0;
                pack_cnt_reg  <= '0;
            end else if (cmd.pk_load || cmd.miss) begin
                pack_buf_reg <= pack_buf_reg | code_in;
                pack_cnt_reg <= pack_cnt_reg + 5'(width_reg);
            end else if (drain_fire) begin
                pack_buf_reg <= pack_buf_reg << 8;
                pack_cnt_reg <= pack_cnt_reg - 5'd8;
            end
            if (cmd.miss && can_add)
                next_free_reg <= next_free_reg + (CW+1)'(1);
            if (cmd.clr)
                clr_addr_reg <= stat.clr_done ? '0 : clr_addr_reg + AW'(1);
            if (drain_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hashed LZW compressor: messages are streamed in
// under random gaps and stalls, an in-bench LZW model with its own hash table
// predicts the packed output words, and every output word is compared in order.
// ----------------------------------------------------------------------------
module tb;
    import lzwc_pkg::*;

    localparam int DEPTH = 74521;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;
    logic             m_tlast;

    lzw_hashed_compressor dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial forever #5 aclk = ~aclk;

    // model state
    logic [16:0] dict_code [DEPTH];
    logic [15:0] dict_prefix [DEPTH];
    logic [7:0]  dict_byte [DEPTH];
    logic [4:0]  width_reg = 5'd12;
    int unsigned msg_w = 12, msg_sz = 5021;
    int unsigned cur_prefix, free_code;
    logic [31:0] bitbuf;
    int unsigned bitcnt;
    bit          in_msg = 0;
    logic [8:0]  expected_words [$];   // {last, byte}
    int          errors = 0;
    int          hold_cycles = 0;
    bit          long_hold = 0;

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $time, what);
        errors++;
    endtask

    function automatic void pack_code(input int unsigned code);
        code &= (1 << msg_w) - 1;
        bitbuf |= code << (32 - msg_w - bitcnt);
        bitcnt += msg_w;
        while (bitcnt >= 8) begin
            expected_words.push_back({1'b0, bitbuf[31:24]});
            bitbuf <<= 8;
            bitcnt -= 8;
        end
    endfunction

    function automatic int unsigned find_slot(input int unsigned pfx, input int unsigned b);
        int unsigned idx, off;
        idx = ((b << (msg_w - 8)) ^ pfx) % msg_sz;
        off = (idx == 0) ? 1 : msg_sz - idx;
        for (int unsigned t = 0; t < msg_sz; t++) begin
            if (dict_code[idx] == 0) return idx;
            if (dict_prefix[idx] == pfx && dict_byte[idx] == b) return idx;
            idx = (idx >= off) ? idx - off : idx + msg_sz - off;
        end
        return idx;
    endfunction

    function automatic void predict_word(input logic [7:0] b, input bit last);
        int unsigned idx;
        if (!in_msg) begin
            msg_w = (width_reg >= 12 && width_reg <= 16) ? width_reg : 12;
            msg_sz = size_for(5'(msg_w));
            for (int i = 0; i < DEPTH; i++) dict_code[i] = '0;
            free_code = 256;
            bitbuf = '0;
            bitcnt = 0;
            cur_prefix = b;
            in_msg = 1;
        end else begin
            idx = find_slot(cur_prefix, b);
            if (dict_code[idx] != 0) begin
                cur_prefix = dict_code[idx] & 16'hFFFF;
            end else begin
                if (free_code <= (1 << msg_w) - 2) begin
                    dict_code[idx] = 17'(free_code);
                    dict_prefix[idx] = 16'(cur_prefix);
                    dict_byte[idx] = b;
                    free_code++;
                end
                pack_code(cur_prefix);
                cur_prefix = b;
            end
        end
        if (last) begin
            pack_code(cur_prefix);
            pack_code((1 << msg_w) - 1);
            pack_code(0);
            pack_code(0);
            expected_words[$][8] = 1'b1;
            in_msg = 0;
        end
    endfunction

    // gap length: mostly short, sometimes long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // tvalid stays high after a word is taken; a later gap, wait_idle or write_width drops it
    task automatic send_byte(input logic [7:0] b, input bit last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        predict_word(b, last);
    endtask

    task automatic send_message(input int len, input int alpha);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, alpha - 1)), i == len - 1);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_width(input logic [4:0] w);
        s_tvalid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        width_reg = w;
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (long_hold && hold_cycles < 400) begin
                m_tready <= 1'b0;
                hold_cycles++;
            end else
                m_tready <= ($urandom_range(0, 99) < 70) ||
                            ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b0);
        end
    end

    // output checker
    initial forever begin
        logic [8:0] exp_w;
        @(posedge aclk);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0)
                report($sformatf("unexpected word %02h", m_tdata));
            else begin
                exp_w = expected_words.pop_front();
                if (m_tdata !== exp_w[7:0])
                    report($sformatf("byte %02h, expected %02h", m_tdata, exp_w[7:0]));
                if (m_tlast !== exp_w[8])
                    report($sformatf("tlast %b, expected %b", m_tlast, exp_w[8]));
            end
        end
    end

    task automatic test_directed();
        write_width(5'd12);
        send_byte(8'h00, 1'b1);               // single-byte message
        send_byte(8'hFF, 1'b1);
        send_byte(8'h41, 1'b0);               // repeated pattern builds hits
        for (int i = 0; i < 8; i++) send_byte(8'h41, i == 7);
        send_byte(8'h55, 1'b0);
        wait_idle();
        write_width(5'd16);                   // write mid-message: next message
        send_byte(8'hAA, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_idle();
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b1);
        wait_idle();
    endtask

    task automatic test_widths();
        logic [4:0] widths [8] = '{5'd13, 5'd14, 5'd15, 5'd16, 5'd0, 5'd31, 5'd11, 5'd17};
        foreach (widths[i]) begin
            write_width(widths[i]);
            send_message($urandom_range(2, 8), 256);
            wait_idle();
        end
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 60) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 20);
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                write_width(5'($urandom_range(12, 16)));
            end
            send_message(len, ($urandom_range(0, 1) != 0) ? 4 : 256);
            sent += len;
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        long_hold = 1;
        send_message(40, 256);
        wait_idle();
        long_hold = 0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_widths();
        test_backpressure();
        test_random();
        wait_idle();
        if (errors == 0)
            $display("** lzw_hashed_compressor: PASSED **");
        else
            $display("** lzw_hashed_compressor: FAILED **");
        $finish;
    end

    // covers the reset table sweep and all stalls with wide margin
    initial begin
        #20ms;
        $display("** lzw_hashed_compressor: FAILED **");
        $finish;
    end

endmodule
